>>> hdl/dlcs_pkg.sv
package dlcs_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int FRAC_BITS  = 16;

    localparam int WIN_W      = 7;
    localparam int TRI_W      = 6;
    localparam int TRI_N      = 1 << TRI_W;
    localparam int CNT_W      = 7;
    localparam int SCORE_W    = 11;
    localparam int VBS_W      = 7;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int BASE_W     = 4;

    localparam int SCALE_W    = 8;
    localparam int PROD_W     = SCORE_W + SCALE_W;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int DEN_W      = 12;
    localparam int DUST_W     = 23;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    localparam logic [WIN_W-1:0]   WIN_RESET = WIN_W'(64);
    localparam logic [WIN_W-1:0]   WIN_MIN   = WIN_W'(3);
    localparam logic [WIN_W-1:0]   WIN_MAX   = WIN_W'(MAX_WINDOW);
    localparam logic [VBS_W-1:0]   VBS_MAX   = VBS_W'(MAX_WINDOW + 3);
    localparam logic [SCALE_W-1:0] SCALE     = SCALE_W'(200);

    localparam logic [BASE_W-1:0] BASE_A = 4'd1;
    localparam logic [BASE_W-1:0] BASE_C = 4'd2;
    localparam logic [BASE_W-1:0] BASE_G = 4'd4;
    localparam logic [BASE_W-1:0] BASE_T = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EVICT,
        ST_DEC,
        ST_READ_T,
        ST_INC,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic [RING_AW-1:0] ring_raddr;
        logic               ring_we;
        logic [RING_AW-1:0] ring_waddr;
        logic [TRI_W-1:0]   ring_wdata;
        logic [TRI_W-1:0]   cnt_raddr;
        logic               cnt_we;
        logic [TRI_W-1:0]   cnt_waddr;
        logic [CNT_W-1:0]   cnt_wdata;
        logic               clear;
    } t_tbl_ctrl;

endpackage

>>> hdl/dlcs_tables.sv
module dlcs_tables (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlcs_pkg::t_tbl_ctrl           i_ctrl,
    output logic [dlcs_pkg::TRI_W-1:0]    o_ring_q,
    output logic [dlcs_pkg::CNT_W-1:0]    o_cnt_q
);
    import dlcs_pkg::*;

    logic [TRI_W-1:0]      ring_mem [MAX_WINDOW];
    logic [CNT_W-1:0]      cnt_mem  [TRI_N];
    logic [MAX_WINDOW-1:0] r_ring_vld;
    logic [TRI_N-1:0]      r_cnt_vld;
    logic [TRI_W-1:0]      r_ring_d;
    logic                  r_ring_v;
    logic [CNT_W-1:0]      r_cnt_d;
    logic                  r_cnt_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_ring_vld <= '0;
            r_cnt_vld  <= '0;
        end else begin
            if (i_ctrl.ring_we) begin
                r_ring_vld[i_ctrl.ring_waddr] <= 1'b1;
            end
            if (i_ctrl.cnt_we) begin
                r_cnt_vld[i_ctrl.cnt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ring_we) begin
            ring_mem[i_ctrl.ring_waddr] <= i_ctrl.ring_wdata;
        end
        if (i_ctrl.cnt_we) begin
            cnt_mem[i_ctrl.cnt_waddr] <= i_ctrl.cnt_wdata;
        end
        r_ring_d <= ring_mem[i_ctrl.ring_raddr];
        r_ring_v <= r_ring_vld[i_ctrl.ring_raddr];
        r_cnt_d  <= cnt_mem[i_ctrl.cnt_raddr];
        r_cnt_v  <= r_cnt_vld[i_ctrl.cnt_raddr];
    end

    // entries not written since the last clear read as zero
    assign o_ring_q = r_ring_v ? r_ring_d : '0;
    assign o_cnt_q  = r_cnt_v  ? r_cnt_d  : '0;

endmodule

>>> hdl/dlcs_div.sv
module dlcs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dlcs_pkg::NUM_W-1:0]    i_num,
    input  logic [dlcs_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [dlcs_pkg::DUST_W-1:0]   o_quot
);
    import dlcs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_q;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[DUST_W-1:0];

endmodule

>>> hdl/dust_low_complexity_score.sv
// channel   dir  handshake                     payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata[3:0] base_code, tlast last_base
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata lc_score, pair_score, triplet_count
// cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_data window_length
//
// A base that forms no triplet passes ST_SHIFT only; while the window fills it
// also passes ST_INC, and once it slides ST_EVICT, ST_DEC, ST_READ_T and ST_INC:
// the count table has one read and one write port, so the evicted and incoming counts
// go through it one after the other. A last base adds ST_MUL, ST_DIV_GO and ST_DIV.
// Sync active-low reset; read state is cleared as each result is loaded (35 quotient bits).
// A result waits in the output register; a new last base stalls until it is taken.
module dust_low_complexity_score (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [dlcs_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // [3:0] base_code
    input  logic                              i_s_axis_tlast,  // last_base
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [22:0] lc_score, [33:23] pair_score, [40:34] triplet_count
    output logic [dlcs_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dlcs_pkg::WIN_W-1:0]        i_cfg_data       // window_length
);
    import dlcs_pkg::*;

    t_state             r_state, n_state;
    logic [BASE_W-1:0]  r_base;
    logic               r_last;
    logic [TRI_W-1:0]   r_shift, n_shift;
    logic [VBS_W-1:0]   r_vbs, n_vbs;
    logic [RING_AW-1:0] r_ring_pos, n_ring_pos;
    logic [SCORE_W-1:0] r_rs, n_rs;
    logic [SCORE_W-1:0] r_peak, n_peak;
    logic [RING_AW-1:0] r_k, n_k;
    logic               r_slid, n_slid;
    logic [TRI_W-1:0]   r_t, n_t;
    logic [TRI_W-1:0]   r_x, n_x;
    logic [WIN_W-1:0]   r_win;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [SCORE_W-1:0] r_pair, n_pair;
    logic [VBS_W-1:0]   r_trips, n_trips;
    logic               r_out_valid;
    logic [DUST_W-1:0]  r_out_dust;
    logic [SCORE_W-1:0] r_out_pair;
    logic [VBS_W-1:0]   r_out_trips;

    logic [WIN_W-1:0]   w_eff;
    logic               b_ok;
    logic [1:0]         b_idx;
    logic [TRI_W-1:0]   sh_new;
    logic [VBS_W-1:0]   vbs_new;
    logic [VBS_W-1:0]   n_trip;
    logic [SCORE_W-1:0] cnt_dec;
    logic [SCORE_W-1:0] rs_sum;
    logic [PROD_W-1:0]  prod;
    logic               div_start;
    logic               div_done;
    logic [DUST_W-1:0]  div_quot;
    logic               load_out;
    t_tbl_ctrl          tbl_ctrl;
    logic [TRI_W-1:0]   tbl_ring_q;
    logic [CNT_W-1:0]   tbl_cnt_q;
    logic               in_acc;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        if (r_win < WIN_MIN) begin
            w_eff = WIN_MIN;
        end else if (r_win > WIN_MAX) begin
            w_eff = WIN_MAX;
        end else begin
            w_eff = r_win;
        end
    end

    always_comb begin
        b_ok  = 1'b1;
        b_idx = 2'd0;
        unique case (r_base)
            BASE_A:  b_idx = 2'd0;
            BASE_C:  b_idx = 2'd1;
            BASE_G:  b_idx = 2'd2;
            BASE_T:  b_idx = 2'd3;
            default: b_ok  = 1'b0;
        endcase
    end

    assign sh_new  = {r_shift[TRI_W-3:0], b_idx};
    assign vbs_new = (r_vbs < VBS_MAX) ? r_vbs + 1'b1 : r_vbs;
    assign n_trip  = vbs_new - VBS_W'(3);
    assign cnt_dec = SCORE_W'(tbl_cnt_q) - 1'b1;
    assign rs_sum  = r_rs + SCORE_W'(tbl_cnt_q);
    assign prod    = (r_vbs > VBS_W'(3))
                   ? ((VBS_W'(r_vbs - VBS_W'(3)) >= w_eff)
                      ? PROD_W'(r_peak) * PROD_W'(SCALE)
                      : PROD_W'(r_rs) * PROD_W'(SCALE))
                   : '0;

    always_comb begin
        logic [WIN_W-1:0] nn;
        logic [WIN_W-1:0] kk;
        nn         = r_vbs - VBS_W'(3);
        kk         = (WIN_W'(r_ring_pos) >= w_eff) ? '0 : WIN_W'(r_ring_pos);
        n_state    = r_state;
        n_shift    = r_shift;
        n_vbs      = r_vbs;
        n_ring_pos = r_ring_pos;
        n_rs       = r_rs;
        n_peak     = r_peak;
        n_k        = r_k;
        n_slid     = r_slid;
        n_t        = r_t;
        n_x        = r_x;
        n_num      = r_num;
        n_den      = r_den;
        n_pair     = r_pair;
        n_trips    = r_trips;
        div_start  = 1'b0;
        load_out   = 1'b0;
        tbl_ctrl   = '0;
        tbl_ctrl.ring_raddr = kk[RING_AW-1:0];
        tbl_ctrl.ring_waddr = r_k;
        tbl_ctrl.ring_wdata = r_t;
        tbl_ctrl.cnt_raddr  = sh_new;
        tbl_ctrl.cnt_waddr  = r_t;
        tbl_ctrl.cnt_wdata  = tbl_cnt_q + 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (b_ok) begin
                    n_shift = sh_new;
                    n_vbs   = vbs_new;
                end
                if (b_ok && vbs_new >= VBS_W'(3)) begin
                    n_k     = kk[RING_AW-1:0];
                    n_t     = sh_new;
                    n_slid  = (n_trip >= w_eff);
                    n_state = (n_trip >= w_eff) ? ST_EVICT : ST_INC;
                end else begin
                    n_state = r_last ? ST_MUL : ST_IDLE;
                end
            end
            ST_EVICT: begin
                n_x                = tbl_ring_q;
                tbl_ctrl.cnt_raddr = tbl_ring_q;
                n_state            = ST_DEC;
            end
            ST_DEC: begin
                if (tbl_cnt_q != '0) begin
                    tbl_ctrl.cnt_we    = 1'b1;
                    tbl_ctrl.cnt_waddr = r_x;
                    tbl_ctrl.cnt_wdata = tbl_cnt_q - 1'b1;
                    n_rs = (r_rs >= cnt_dec) ? r_rs - cnt_dec : '0;
                end
                n_state = ST_READ_T;
            end
            ST_READ_T: begin
                tbl_ctrl.cnt_raddr = r_t;
                n_state            = ST_INC;
            end
            ST_INC: begin
                n_rs             = rs_sum;
                tbl_ctrl.cnt_we  = 1'b1;
                tbl_ctrl.ring_we = 1'b1;
                if (r_slid && rs_sum > r_peak) begin
                    n_peak = rs_sum;
                end
                n_ring_pos = ((WIN_W'(r_k) + 1'b1) >= w_eff) ? '0 : r_k + 1'b1;
                n_state    = r_last ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                if (!r_out_valid) begin
                    n_trips = (r_vbs >= VBS_W'(2)) ? r_vbs - VBS_W'(2) : '0;
                    n_num   = {prod, FRAC_BITS'(0)};
                    if (r_vbs > VBS_W'(3)) begin
                        if (nn >= w_eff) begin
                            n_pair = r_peak;
                            n_den  = DEN_W'(w_eff) * DEN_W'(w_eff - 1'b1);
                        end else begin
                            n_pair = r_rs;
                            n_den  = DEN_W'(nn) * DEN_W'(nn + 1'b1);
                        end
                    end else begin
                        n_pair = '0;
                        n_den  = DEN_W'(1);
                    end
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    load_out       = 1'b1;
                    tbl_ctrl.clear = 1'b1;
                    n_shift        = '0;
                    n_vbs          = '0;
                    n_ring_pos     = '0;
                    n_rs           = '0;
                    n_peak         = '0;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_shift     <= '0;
            r_vbs       <= '0;
            r_ring_pos  <= '0;
            r_rs        <= '0;
            r_peak      <= '0;
            r_slid      <= 1'b0;
            r_last      <= 1'b0;
            r_win       <= WIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_shift    <= n_shift;
            r_vbs      <= n_vbs;
            r_ring_pos <= n_ring_pos;
            r_rs       <= n_rs;
            r_peak     <= n_peak;
            r_slid     <= n_slid;
            if (in_acc) begin
                r_last <= i_s_axis_tlast;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_win <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_base <= i_s_axis_tdata[BASE_W-1:0];
        end
        r_k     <= n_k;
        r_t     <= n_t;
        r_x     <= n_x;
        r_num   <= n_num;
        r_den   <= n_den;
        r_pair  <= n_pair;
        r_trips <= n_trips;
        if (load_out) begin
            r_out_dust  <= div_quot;
            r_out_pair  <= r_pair;
            r_out_trips <= r_trips;
        end
    end

    dlcs_tables u_tables (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (tbl_ctrl),
        .o_ring_q (tbl_ring_q),
        .o_cnt_q  (tbl_cnt_q)
    );

    dlcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - DUST_W - SCORE_W - VBS_W)'(0),
                              r_out_trips, r_out_pair, r_out_dust};

endmodule
